[rtl/core/wfa_pkg.sv]
// Shared widths, function codes and controller states for the worst-fit allocator.
`default_nettype none

package wfa_pkg;

    // Table depth default
    localparam int MAX_BLOCKS_DEF = 32;

    // Field widths
    localparam int FUNC_W   = 1;
    localparam int COUNT_W  = 6;
    localparam int INDEX_W  = 5;
    localparam int SIZE_W   = 16;
    localparam int NUMBER_W = 6;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

[rtl/core/wfa_mem.sv]
// Block size memory: one write port, one read port with a registered read.
`default_nettype none

module wfa_mem #(
    parameter int DEPTH = wfa_pkg::MAX_BLOCKS_DEF,
    parameter int AW    = 5
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [wfa_pkg::SIZE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [wfa_pkg::SIZE_W-1:0] rd_data
);
    import wfa_pkg::*;

    logic [SIZE_W-1:0] mem [DEPTH];
    logic [SIZE_W-1:0] rd_data_reg;

    // Write a loaded size
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry per cycle for the scan
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/wfa_ctrl.sv]
// Allocator controller: count register, used flags, scan sequencer and result registers.
`default_nettype none

module wfa_ctrl #(
    parameter int MAX_BLOCKS = wfa_pkg::MAX_BLOCKS_DEF,
    parameter int AW         = 5,
    parameter int NW         = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wfa_pkg::FUNC_W-1:0]   func,
    input  logic [wfa_pkg::INDEX_W-1:0]  block_index,
    input  logic [wfa_pkg::SIZE_W-1:0]   block_size_in,
    input  logic [wfa_pkg::SIZE_W-1:0]   request_size,
    input  logic                         cfg_wr,
    input  logic [wfa_pkg::COUNT_W-1:0]  cfg_data,
    output logic                         busy,
    output logic                         done,
    output logic                         granted,
    output logic [wfa_pkg::NUMBER_W-1:0] block_number,
    output logic [wfa_pkg::SIZE_W-1:0]   leftover,
    output logic                         mem_wr_en,
    output logic [AW-1:0]                mem_wr_addr,
    output logic [wfa_pkg::SIZE_W-1:0]   mem_wr_data,
    output logic                         mem_rd_en,
    output logic [AW-1:0]                mem_rd_addr,
    input  logic [wfa_pkg::SIZE_W-1:0]   mem_rd_data
);
    import wfa_pkg::*;

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [MAX_BLOCKS-1:0] used_reg, used_next;
    logic [AW-1:0]         cnt_reg, cnt_next;
    logic [SIZE_W-1:0]     req_reg, req_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic                  found_reg, found_next;
    logic [SIZE_W-1:0]     best_size_reg, best_size_next;
    logic [AW-1:0]         best_idx_reg, best_idx_next;
    logic                  done_reg, done_next;
    logic                  granted_reg, granted_next;
    logic [NUMBER_W-1:0]   number_reg, number_next;
    logic [SIZE_W-1:0]     leftover_reg, leftover_next;

    logic [NW-1:0]         live_n;
    logic                  accept;
    logic                  load_ok;
    logic                  cnt_last;
    logic                  hit;

    // Clamp the count to the table depth
    assign live_n = (int'(count_reg) > MAX_BLOCKS) ? NW'(MAX_BLOCKS) : NW'(count_reg);

    assign accept   = start && (state_reg == ST_IDLE);
    assign load_ok  = accept && (func == FUNC_LOAD) && (int'(block_index) < int'(live_n));
    assign cnt_last = ((NW+1)'(cnt_reg) + (NW+1)'(1)) == (NW+1)'(live_n);

    // Drive the memory ports
    assign mem_wr_en   = load_ok;
    assign mem_wr_addr = AW'(block_index);
    assign mem_wr_data = block_size_in;
    assign mem_rd_en   = (state_reg == ST_SCAN);
    assign mem_rd_addr = cnt_reg;

    // Compare the entry returned by the memory against the best so far
    assign hit = rd_valid_reg && !used_reg[rd_idx_reg] && (mem_rd_data >= req_reg)
                 && (!found_reg || (mem_rd_data > best_size_reg));

    // Next state, scan tracking and results
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        cnt_next       = cnt_reg;
        req_next       = req_reg;
        rd_valid_next  = (state_reg == ST_SCAN);
        rd_idx_next    = cnt_reg;
        found_next     = found_reg;
        best_size_next = best_size_reg;
        best_idx_next  = best_idx_reg;
        done_next      = 1'b0;
        granted_next   = granted_reg;
        number_next    = number_reg;
        leftover_next  = leftover_reg;

        if (cfg_wr)
        begin
            count_next = cfg_data;
        end

        if (hit)
        begin
            found_next     = 1'b1;
            best_size_next = mem_rd_data;
            best_idx_next  = rd_idx_reg;
        end

        if (load_ok)
        begin
            used_next[AW'(block_index)] = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == FUNC_REQUEST))
                begin
                    req_next   = request_size;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    state_next = (live_n == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                done_next    = 1'b1;
                granted_next = found_reg;
                if (found_reg)
                begin
                    used_next[best_idx_reg] = 1'b1;
                    number_next   = NUMBER_W'({1'b0, best_idx_reg} + (AW+1)'(1));
                    leftover_next = best_size_reg - req_reg;
                end
                else
                begin
                    number_next   = '0;
                    leftover_next = '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            used_reg     <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            used_reg     <= used_next;
            rd_valid_reg <= rd_valid_next;
            found_reg    <= found_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        req_reg       <= req_next;
        rd_idx_reg    <= rd_idx_next;
        best_size_reg <= best_size_next;
        best_idx_reg  <= best_idx_next;
        granted_reg   <= granted_next;
        number_reg    <= number_next;
        leftover_reg  <= leftover_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign granted      = granted_reg;
    assign block_number = number_reg;
    assign leftover     = leftover_reg;

endmodule

`default_nettype wire

[rtl/core/worst_fit_block_allocator_core.sv]
// Worst-fit block allocator top level: size memory and scan controller.
//
// Channel   | Handshake              | Payload
// ----------+------------------------+-----------------------------------------------
// item in   | start, busy            | func, block_index, block_size_in, request_size
// result    | done (one-cycle beat)  | granted, block_number, leftover
// config    | cfg_valid, cfg_ready   | cfg_data (block_count)
//
// A load beat completes in the cycle it is taken; busy stays low.
// A request beat holds busy while it scans the first block_count entries, clamped to MAX_BLOCKS:
// one memory read per table entry, set by the single read port, then a compare drain
// and an emit. done pulses in the cycle after the emit; busy is already low then.
// The receiver cannot stall; config is held off while busy or while start is high.
// Reset clears the count and all used flags; sizes are undefined until loaded.
`default_nettype none

module worst_fit_block_allocator_core #(
    parameter int MAX_BLOCKS = wfa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [wfa_pkg::FUNC_W-1:0]   func,
    input  logic [wfa_pkg::INDEX_W-1:0]  block_index,
    input  logic [wfa_pkg::SIZE_W-1:0]   block_size_in,
    input  logic [wfa_pkg::SIZE_W-1:0]   request_size,
    output logic                         done,
    output logic                         granted,
    output logic [wfa_pkg::NUMBER_W-1:0] block_number,
    output logic [wfa_pkg::SIZE_W-1:0]   leftover,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [wfa_pkg::COUNT_W-1:0]  cfg_data
);
    import wfa_pkg::*;

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NW = $clog2(MAX_BLOCKS + 1);

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [SIZE_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [SIZE_W-1:0] mem_rd_data;

    // Take configuration only between requests, never beside an item beat
    assign cfg_ready = !busy && !start;

    wfa_mem #(
        .DEPTH (MAX_BLOCKS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    wfa_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .AW         (AW),
        .NW         (NW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .func          (func),
        .block_index   (block_index),
        .block_size_in (block_size_in),
        .request_size  (request_size),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .busy          (busy),
        .done          (done),
        .granted       (granted),
        .block_number  (block_number),
        .leftover      (leftover),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data)
    );

endmodule

`default_nettype wire

[rtl/core/wfa_checker.sv]
// Port-level checks for the worst-fit allocator and their binding to the top level.
`default_nettype none

module wfa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [wfa_pkg::FUNC_W-1:0]   func,
    input logic                         done,
    input logic                         granted,
    input logic [wfa_pkg::NUMBER_W-1:0] block_number,
    input logic [wfa_pkg::SIZE_W-1:0]   leftover
);
    import wfa_pkg::*;

    // A result beat only appears once the controller is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // A grant names a real block
    a_grant_number: assert property (@(posedge clk) disable iff (!rst_n)
        (done && granted) |-> (block_number != '0))
        else $error("grant with block number zero");

    // A refusal carries zero number and zero leftover
    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !granted) |-> ((block_number == '0) && (leftover == '0)))
        else $error("refusal with non-zero payload");

    // A request beat starts a scan
    a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_REQUEST)) |=> busy)
        else $error("request did not start a scan");

    // A load beat gives no result and frees the port at once
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == FUNC_LOAD)) |=> (!busy && !done))
        else $error("load produced a result or held busy");

endmodule

bind worst_fit_block_allocator_core wfa_checker u_wfa_checker (.*);

`default_nettype wire
